// ----- rtl/core/lrtm_pkg.sv -----
`default_nettype none

package lrtm_pkg;

    localparam int RULES_DEF      = 64;
    localparam int STATE_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FIND  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ANY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DIGIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_XDIGIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ALPHA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ALNUM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SPACE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BLANK  = 3'd7;

    localparam logic [6:0] RST_RULE_COUNT  = 7'd0;
    localparam logic [7:0] RST_CODE_ANY    = 8'd128;
    localparam logic [7:0] RST_CODE_DIGIT  = 8'd129;
    localparam logic [7:0] RST_CODE_XDIGIT = 8'd130;
    localparam logic [7:0] RST_CODE_ALPHA  = 8'd131;
    localparam logic [7:0] RST_CODE_ALNUM  = 8'd132;
    localparam logic [7:0] RST_CODE_SPACE  = 8'd133;
    localparam logic [7:0] RST_CODE_BLANK  = 8'd134;

    typedef struct packed {
        logic [7:0] c_any;
        logic [7:0] c_digit;
        logic [7:0] c_xdigit;
        logic [7:0] c_alpha;
        logic [7:0] c_alnum;
        logic [7:0] c_space;
        logic [7:0] c_blank;
    } lrtm_codes_t;

    typedef struct packed {
        logic        operation;
        logic [5:0]  entry_index;
        logic [7:0]  state_id;
        logic [7:0]  symbol;
        logic [15:0] rule_action;
        logic [7:0]  rule_next_state;
    } lrtm_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POST
    } lrtm_state_t;

    typedef struct packed {
        logic start;
        logic wr_en;
        logic scan;
        logic load_out;
    } lrtm_cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } lrtm_status_t;

    function automatic logic trigger_hits(input logic [7:0] trig, input logic [7:0] c,
                                          input lrtm_codes_t codes);
        logic dig;
        logic alp;
        logic hex;
        logic spc;
        logic blk;
        dig = (c >= 8'h30) && (c <= 8'h39);
        alp = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
        hex = dig || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
        spc = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
        blk = (c == 8'h20) || (c == 8'h09);
        return (trig == c)
            || (trig == codes.c_any)
            || ((trig == codes.c_digit) && dig)
            || ((trig == codes.c_xdigit) && hex)
            || ((trig == codes.c_alpha) && alp)
            || ((trig == codes.c_alnum) && (alp || dig))
            || ((trig == codes.c_space) && spc)
            || ((trig == codes.c_blank) && blk);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lrtm_in_if.sv -----
`default_nettype none

interface lrtm_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [5:0]  entry_index;
    logic [7:0]  state_id;
    logic [7:0]  symbol;
    logic [15:0] rule_action;
    logic [7:0]  rule_next_state;

    modport source (
        output valid, operation, entry_index, state_id, symbol, rule_action,
               rule_next_state,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, state_id, symbol, rule_action,
               rule_next_state,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/lrtm_out_if.sv -----
`default_nettype none

interface lrtm_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [5:0]  match_index;
    logic [15:0] match_action;
    logic [7:0]  match_next_state;

    modport source (
        output valid, found, match_index, match_action, match_next_state,
        input  ready
    );
    modport sink (
        input  valid, found, match_index, match_action, match_next_state,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/lrtm_cfg_if.sv -----
`default_nettype none

interface lrtm_cfg_if import lrtm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/lrtm_ctrl.sv -----
`default_nettype none

module lrtm_ctrl import lrtm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire logic   in_operation,
    output logic        in_ready,
    input  wire lrtm_status_t status,
    output lrtm_cmd_t   cmd
);

    lrtm_state_t state_reg;
    lrtm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (in_operation == OP_WRITE)
                    begin
                        cmd.wr_en  = 1'b1;
                        state_next = ST_POST;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.exhausted)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/lrtm_dpath.sv -----
`default_nettype none

module lrtm_dpath import lrtm_pkg::*;
#(
    parameter int RULES      = RULES_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire lrtm_item_t item,
    input  wire lrtm_cmd_t  cmd,
    output lrtm_status_t status,
    lrtm_cfg_if.sink    cfg_ch,
    lrtm_out_if.source  out_ch
);

    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int LIM_W = ($clog2(RULES + 1) > 7) ? $clog2(RULES + 1) : 7;

    typedef struct packed {
        logic [STATE_BITS-1:0] st;
        logic [7:0]            trigger;
        logic [15:0]           action;
        logic [STATE_BITS-1:0] nxt;
    } entry_t;

    entry_t mem [RULES];

    logic [6:0]            rule_count_reg;
    lrtm_codes_t           codes_reg;
    logic [STATE_BITS-1:0] st_reg;
    logic [7:0]            sym_reg;
    logic [LIM_W-1:0]      addr_reg;
    logic [LIM_W-1:0]      pidx_reg;
    logic                  pend_reg;
    entry_t                rd_reg;
    logic                  m_found_reg;
    logic [5:0]            m_idx_reg;
    logic [15:0]           m_act_reg;
    logic [7:0]            m_next_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [5:0]            out_idx_reg;
    logic [15:0]           out_act_reg;
    logic [7:0]            out_next_reg;

    logic [LIM_W-1:0] limit;
    logic             hit;
    logic             more;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg     <= RST_RULE_COUNT;
            codes_reg.c_any    <= RST_CODE_ANY;
            codes_reg.c_digit  <= RST_CODE_DIGIT;
            codes_reg.c_xdigit <= RST_CODE_XDIGIT;
            codes_reg.c_alpha  <= RST_CODE_ALPHA;
            codes_reg.c_alnum  <= RST_CODE_ALNUM;
            codes_reg.c_space  <= RST_CODE_SPACE;
            codes_reg.c_blank  <= RST_CODE_BLANK;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_RULE_COUNT:  rule_count_reg     <= cfg_ch.data[6:0];
                CFG_CODE_ANY:    codes_reg.c_any    <= cfg_ch.data;
                CFG_CODE_DIGIT:  codes_reg.c_digit  <= cfg_ch.data;
                CFG_CODE_XDIGIT: codes_reg.c_xdigit <= cfg_ch.data;
                CFG_CODE_ALPHA:  codes_reg.c_alpha  <= cfg_ch.data;
                CFG_CODE_ALNUM:  codes_reg.c_alnum  <= cfg_ch.data;
                CFG_CODE_SPACE:  codes_reg.c_space  <= cfg_ch.data;
                CFG_CODE_BLANK:  codes_reg.c_blank  <= cfg_ch.data;
                default:         rule_count_reg     <= rule_count_reg;
            endcase
        end
    end

    assign limit = (LIM_W'(rule_count_reg) > LIM_W'(RULES)) ? LIM_W'(RULES)
                                                             : LIM_W'(rule_count_reg);
    assign more  = addr_reg < limit;
    assign hit   = pend_reg && (rd_reg.st == st_reg)
                   && trigger_hits(rd_reg.trigger, sym_reg, codes_reg);

    assign status.hit       = hit;
    assign status.exhausted = !pend_reg && !more;
    assign status.out_free  = !out_valid_reg || out_ch.ready;

    // Table writes and the registered read port of the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (32'(item.entry_index) < RULES))
        begin
            mem[IDX_W'(item.entry_index)] <= '{st:      STATE_BITS'(item.state_id),
                                               trigger: item.symbol,
                                               action:  item.rule_action,
                                               nxt:     STATE_BITS'(item.rule_next_state)};
        end
        if (cmd.scan && !hit && more)
        begin
            rd_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            st_reg  <= STATE_BITS'(item.state_id);
            sym_reg <= item.symbol;
        end
    end

    // A scan cycle checks the entry read last and on a miss reads the next, if any.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            pidx_reg    <= '0;
            pend_reg    <= 1'b0;
            m_found_reg <= 1'b0;
            m_idx_reg   <= '0;
            m_act_reg   <= '0;
            m_next_reg  <= '0;
        end
        else if (cmd.start)
        begin
            addr_reg    <= '0;
            pend_reg    <= 1'b0;
            m_found_reg <= 1'b0;
            m_idx_reg   <= '0;
            m_act_reg   <= '0;
            m_next_reg  <= '0;
        end
        else if (cmd.scan)
        begin
            if (hit)
            begin
                m_found_reg <= 1'b1;
                m_idx_reg   <= pidx_reg[5:0];
                m_act_reg   <= rd_reg.action;
                m_next_reg  <= 8'(rd_reg.nxt);
                pend_reg    <= 1'b0;
            end
            else if (more)
            begin
                pidx_reg <= addr_reg;
                addr_reg <= addr_reg + 1'b1;
                pend_reg <= 1'b1;
            end
            else
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg <= m_found_reg;
            out_idx_reg   <= m_idx_reg;
            out_act_reg   <= m_act_reg;
            out_next_reg  <= m_next_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.found            = out_found_reg;
    assign out_ch.match_index      = out_idx_reg;
    assign out_ch.match_action     = out_act_reg;
    assign out_ch.match_next_state = out_next_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lexer_rule_table_match_unit.sv -----
// A write item goes to the post state and yields its result once the output register is free.
// A find item scans entries 0 to min(rule_count, RULES) - 1 in order and yields its
// result on the first hit or when that range is exhausted: the table has a single
// registered read port and the scan checks one entry per cycle.
// A new item is accepted once the previous result sits in the output register.
// Reset clears the control state and loads the configuration registers with their defaults; table entries hold
// no reset value.
`default_nettype none

module lexer_rule_table_match_unit import lrtm_pkg::*;
#(
    parameter int RULES      = RULES_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lrtm_in_if.sink    in_ch,
    lrtm_out_if.source out_ch,
    lrtm_cfg_if.sink   cfg_ch
);

    lrtm_item_t   item;
    lrtm_cmd_t    cmd;
    lrtm_status_t status;
    logic         in_ready;

    assign item.operation       = in_ch.operation;
    assign item.entry_index     = in_ch.entry_index;
    assign item.state_id        = in_ch.state_id;
    assign item.symbol          = in_ch.symbol;
    assign item.rule_action     = in_ch.rule_action;
    assign item.rule_next_state = in_ch.rule_next_state;
    assign in_ch.ready          = in_ready;

    lrtm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_operation (in_ch.operation),
        .in_ready     (in_ready),
        .status       (status),
        .cmd          (cmd)
    );

    lrtm_dpath #(
        .RULES      (RULES),
        .STATE_BITS (STATE_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
